// File: design/pdsc_pkg.sv
// Shared types and constants for the packet deframer with sum check.
`default_nettype none
package pdsc_pkg;

  // Header is type, flags, length, then the header sum byte
  localparam int unsigned HEADER_BYTES = 4;
  localparam logic [7:0]  HEADER_LAST  = 8'(HEADER_BYTES - 1);

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // End item status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_HDR_BAD = 2'd1,
    STATUS_PAY_BAD = 2'd2
  } status_t;

  // Kind of a queued item
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  // Deframer phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_CHECK   = 3'b100
  } phase_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
    logic [7:0] ptype;
    logic [7:0] flags;
    logic [7:0] length;
  } cmd_t;

endpackage
`default_nettype wire

// File: design/packet_deframer_sum_check_unit.sv
// Top level of the length-prefixed packet deframer with 8-bit sum checks.
// Takes one received byte per clock on rx_valid/rx_stall and gives payload and
// end items on item_valid/item_stall. Sustained rate is one byte per cycle while
// the sink does not stall; each result passes through the queue and then the
// output register. The framing state in the front end is updated once per byte;
// a QUEUE_DEPTH-entry queue then an output register decouple it from the sink,
// so input is stalled only when the queue is full. Status on an end item is
// 0 ok, 1 header sum bad (block resumes header hunting), 2 payload sum bad.
`default_nettype none
module packet_deframer_sum_check_unit #(
  parameter int unsigned QUEUE_DEPTH = pdsc_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_stall,
  input  wire logic [7:0] rx_byte,
  output logic            item_valid,
  input  wire logic       item_stall,
  output logic            is_end,
  output logic [7:0]      data_byte,
  output logic [1:0]      status,
  output logic [7:0]      packet_type,
  output logic [7:0]      packet_flags,
  output logic [7:0]      payload_length
);
  import pdsc_pkg::*;

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic push;
  logic q_full;
  logic q_not_empty;
  logic q_pop;

  // Framing and classification
  pdsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .queue_full (q_full),
    .push       (push),
    .cmd        (front_cmd)
  );

  // Decoupling queue
  pdsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_cmd   (q_cmd)
  );

  // Result formatting and output register
  pdsc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (q_not_empty),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .is_end         (is_end),
    .data_byte      (data_byte),
    .status         (status),
    .packet_type    (packet_type),
    .packet_flags   (packet_flags),
    .payload_length (payload_length)
  );

endmodule
`default_nettype wire

// File: design/pdsc_front.sv
// Front end: accepts received bytes, tracks framing and classifies them.
`default_nettype none
module pdsc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rx_valid,
  output logic               rx_stall,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          queue_full,
  output logic               push,
  output pdsc_pkg::cmd_t     cmd
);
  import pdsc_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] held_type, held_type_next;
  logic [7:0] held_flags, held_flags_next;
  logic [7:0] held_length, held_length_next;
  logic       rx_accept;
  logic       emit;
  logic [7:0] count_inc;
  logic [7:0] sum_inc;

  // Only a full queue holds off the link
  assign rx_stall  = queue_full;
  assign rx_accept = rx_valid && !rx_stall;
  assign push      = rx_accept && emit;
  assign count_inc = byte_count + 8'd1;
  assign sum_inc   = running_sum + rx_byte;

  // Framing decisions for the byte on the input
  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    held_type_next   = held_type;
    held_flags_next  = held_flags;
    held_length_next = held_length;
    emit             = 1'b0;
    cmd.kind         = KIND_END;
    cmd.data         = rx_byte;
    cmd.status       = STATUS_OK;
    cmd.ptype        = held_type;
    cmd.flags        = held_flags;
    cmd.length       = held_length;
    unique case (phase)
      PH_PAYLOAD: begin
        running_sum_next = sum_inc;
        byte_count_next  = count_inc;
        if (count_inc >= held_length) begin
          phase_next = PH_CHECK;
        end
        emit     = 1'b1;
        cmd.kind = KIND_PAYLOAD;
      end
      PH_CHECK: begin
        emit             = 1'b1;
        cmd.status       = (rx_byte == running_sum) ? STATUS_OK : STATUS_PAY_BAD;
        phase_next       = PH_HEADER;
        byte_count_next  = '0;
        running_sum_next = '0;
      end
      PH_HEADER: begin
        if (byte_count >= HEADER_LAST) begin
          // header sum byte
          byte_count_next  = '0;
          running_sum_next = '0;
          if (rx_byte != running_sum) begin
            emit       = 1'b1;
            cmd.status = STATUS_HDR_BAD;
          end else if (held_length == 8'd0) begin
            emit = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end else begin
          if (byte_count == 8'd0) begin
            held_type_next = rx_byte;
          end else if (byte_count == 8'd1) begin
            held_flags_next = rx_byte;
          end else begin
            held_length_next = rx_byte;
          end
          running_sum_next = sum_inc;
          byte_count_next  = count_inc;
        end
      end
      default: begin
        phase_next       = PH_HEADER;
        byte_count_next  = '0;
        running_sum_next = '0;
      end
    endcase
  end

  // Framing state, updated on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      byte_count  <= '0;
      running_sum <= '0;
      held_type   <= '0;
      held_flags  <= '0;
      held_length <= '0;
    end else if (rx_accept) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
      held_type   <= held_type_next;
      held_flags  <= held_flags_next;
      held_length <= held_length_next;
    end
  end

  // Header count never passes the sum byte position
  a_hdr_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEADER) |-> (byte_count <= HEADER_LAST))
    else $error("header byte count out of range");

  // Every payload byte transfer yields a payload item
  a_payload_push: assert property (@(posedge clk) disable iff (rst)
    (rx_accept && phase == PH_PAYLOAD) |-> (push && cmd.kind == KIND_PAYLOAD))
    else $error("payload byte did not produce a payload item");

  // Leading header bytes produce nothing
  a_hdr_quiet: assert property (@(posedge clk) disable iff (rst)
    (rx_accept && phase == PH_HEADER && byte_count < HEADER_LAST) |-> !push)
    else $error("item emitted on a leading header byte");

endmodule
`default_nettype wire

// File: design/pdsc_queue.sv
// Short queue of classified items between the front and the back.
`default_nettype none
module pdsc_queue #(
  parameter int unsigned DEPTH = pdsc_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire pdsc_pkg::cmd_t push_cmd,
  output logic                full,
  output logic                not_empty,
  input  wire logic           pop,
  output pdsc_pkg::cmd_t      pop_cmd
);
  import pdsc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  cmd_t            entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == CntFull);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Fill count stays within the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntFull)
    else $error("queue count exceeds depth");

  // The front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  // Count rises by one on a push without a pop
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule
`default_nettype wire

// File: design/pdsc_back.sv
// Back end: formats queued items into result fields and holds them for the sink.
`default_nettype none
module pdsc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_not_empty,
  input  wire pdsc_pkg::cmd_t q_cmd,
  output logic                q_pop,
  output logic                item_valid,
  input  wire logic           item_stall,
  output logic                is_end,
  output logic [7:0]          data_byte,
  output logic [1:0]          status,
  output logic [7:0]          packet_type,
  output logic [7:0]          packet_flags,
  output logic [7:0]          payload_length
);
  import pdsc_pkg::*;

  logic load;
  logic end_item;

  // Refill the output register whenever it is free or being taken
  assign load     = q_not_empty && (!item_valid || !item_stall);
  assign q_pop    = load;
  assign end_item = (q_cmd.kind == KIND_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (!item_stall) begin
      item_valid <= 1'b0;
    end
  end

  // Payload items carry only the byte; end items carry header and status
  always_ff @(posedge clk) begin
    if (load) begin
      is_end         <= end_item;
      data_byte      <= end_item ? 8'd0 : q_cmd.data;
      status         <= end_item ? q_cmd.status : STATUS_OK;
      packet_type    <= end_item ? q_cmd.ptype : 8'd0;
      packet_flags   <= end_item ? q_cmd.flags : 8'd0;
      payload_length <= end_item ? q_cmd.length : 8'd0;
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/packet_deframer_sum_check_unit_test.sv
// Self-checking testbench for the packet deframer with 8-bit sum checks.
`default_nettype none
module packet_deframer_sum_check_unit_test;
  import pdsc_pkg::*;

  localparam int unsigned RANDOM_BYTES = 800;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One result item as seen on the output ports
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
    logic [7:0] ptype;
    logic [7:0] flags;
    logic [7:0] length;
  } frame_item_t;

  // Directed stimulus row; the result is typed in where it is obvious
  typedef struct {
    logic [7:0]  rx;
    bit          typed;
    bit          yields;
    frame_item_t want;
  } directed_row_t;

  logic       clk;
  logic       rst;
  logic       rx_valid;
  logic       rx_stall;
  logic [7:0] rx_byte;
  logic       item_valid;
  logic       item_stall;
  logic       is_end;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic [7:0] packet_type;
  logic [7:0] packet_flags;
  logic [7:0] payload_length;

  packet_deframer_sum_check_unit dut (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .is_end         (is_end),
    .data_byte      (data_byte),
    .status         (status),
    .packet_type    (packet_type),
    .packet_flags   (packet_flags),
    .payload_length (payload_length)
  );

  // Deframer state mirrored by the predictor
  phase_t     hunt_phase;
  logic [7:0] seen_count;
  logic [7:0] seen_sum;
  logic [7:0] held_type;
  logic [7:0] held_flags;
  logic [7:0] held_length;

  frame_item_t   pending_items[$];
  directed_row_t directed_rows[$];
  int unsigned   errors;
  int unsigned   cycles;
  int unsigned   sent_bytes;
  int unsigned   sink_wait;
  bit            src_quiet;
  bit            sink_quiet;

  always #1 clk = ~clk;

  // End-of-frame item built from the held header bytes
  function automatic frame_item_t frame_end(status_t st);
    frame_item_t it;
    it        = '0;
    it.kind   = KIND_END;
    it.status = st;
    it.ptype  = held_type;
    it.flags  = held_flags;
    it.length = held_length;
    return it;
  endfunction

  function automatic void rehunt();
    hunt_phase = PH_HEADER;
    seen_count = 8'd0;
    seen_sum   = 8'd0;
  endfunction

  // Advance the mirrored deframer by one byte; returns 1 when a result is due
  function automatic bit deframe_step(input logic [7:0] b, output frame_item_t it);
    it = '0;
    case (hunt_phase)
      PH_PAYLOAD: begin
        seen_sum   = seen_sum + b;
        seen_count = seen_count + 8'd1;
        if (seen_count >= held_length) hunt_phase = PH_CHECK;
        it.kind = KIND_PAYLOAD;
        it.data = b;
        return 1'b1;
      end
      PH_CHECK: begin
        it = frame_end((b == seen_sum) ? STATUS_OK : STATUS_PAY_BAD);
        rehunt();
        return 1'b1;
      end
      default: begin
        // header sum byte: verdict on the header
        if (seen_count >= HEADER_LAST) begin
          if (b != seen_sum) begin
            it = frame_end(STATUS_HDR_BAD);
            rehunt();
            return 1'b1;
          end
          if (held_length == 8'd0) begin
            it = frame_end(STATUS_OK);
            rehunt();
            return 1'b1;
          end
          hunt_phase = PH_PAYLOAD;
          seen_count = 8'd0;
          seen_sum   = 8'd0;
          return 1'b0;
        end
        case (seen_count)
          8'd0:    held_type  = b;
          8'd1:    held_flags = b;
          default: held_length = b;
        endcase
        seen_sum   = seen_sum + b;
        seen_count = seen_count + 8'd1;
        hunt_phase = PH_HEADER;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void put_row(logic [7:0] b, bit typed = 1'b0, bit yields = 1'b0,
                                  frame_item_t want = '0);
    directed_row_t r;
    r.rx     = b;
    r.typed  = typed;
    r.yields = yields;
    r.want   = want;
    directed_rows.push_back(r);
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    end
  endfunction

  // Drive one byte after a random gap and record what it should produce
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input bit yields = 1'b0, input frame_item_t want = '0);
    int unsigned gap;
    frame_item_t got;
    gap = src_quiet ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 29) == 0) src_quiet = !src_quiet;
    if (gap != 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    if (deframe_step(b, got) && !typed) pending_items.push_back(got);
    if (typed && yields) pending_items.push_back(want);
    sent_bytes++;
    @(negedge clk);
  endtask

  // One random frame, mostly well formed
  task automatic send_frame();
    logic [7:0] ftype;
    logic [7:0] fflags;
    logic [7:0] flen;
    logic [7:0] fsum;
    logic [7:0] pb;
    ftype  = 8'($urandom_range(0, 255));
    fflags = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 2)
      flen = ($urandom_range(0, 2) == 0) ? 8'd255 : 8'($urandom_range(128, 254));
    else
      flen = 8'($urandom_range(0, 10));
    fsum = ftype + fflags + flen;
    if ($urandom_range(0, 9) == 0) fsum = fsum ^ 8'($urandom_range(1, 255));
    send_byte(ftype);
    send_byte(fflags);
    send_byte(flen);
    send_byte(fsum);
    if (fsum != 8'(ftype + fflags + flen) || flen == 8'd0) return;
    fsum = 8'd0;
    repeat (flen) begin
      pb   = 8'($urandom_range(0, 255));
      fsum = fsum + pb;
      send_byte(pb);
    end
    if ($urandom_range(0, 9) == 0) fsum = fsum ^ 8'($urandom_range(1, 255));
    send_byte(fsum);
  endtask

  // Output side: random stall per item, check each transfer in order
  always @(negedge clk) begin
    item_stall <= (sink_wait != 0);
    if (sink_wait != 0) sink_wait--;
  end

  always @(posedge clk) begin
    frame_item_t exp_item;
    if (!rst && item_valid && !item_stall) begin
      if (pending_items.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none actual end=%0b data=%0h status=%0d",
                 $time, is_end, data_byte, status);
      end else begin
        exp_item = pending_items.pop_front();
        check_field("is_end", 32'(exp_item.kind), 32'(is_end));
        check_field("data_byte", 32'(exp_item.data), 32'(data_byte));
        check_field("status", 32'(exp_item.status), 32'(status));
        check_field("packet_type", 32'(exp_item.ptype), 32'(packet_type));
        check_field("packet_flags", 32'(exp_item.flags), 32'(packet_flags));
        check_field("payload_length", 32'(exp_item.length), 32'(payload_length));
      end
      sink_wait = sink_quiet ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 29) == 0) sink_quiet = !sink_quiet;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("packet_deframer_sum_check_unit verification failed");
      $finish;
    end
  end

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    rx_valid   = 1'b0;
    rx_byte    = 8'd0;
    item_stall = 1'b0;
    errors     = 0;
    cycles     = 0;
    sent_bytes = 0;
    sink_wait  = 0;
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
    held_type  = 8'd0;
    held_flags = 8'd0;
    held_length = 8'd0;
    rehunt();

    // Bad header sum straight after reset, all-zero header bytes
    put_row(8'h00, 1'b1);
    put_row(8'h00, 1'b1);
    put_row(8'h00, 1'b1);
    put_row(8'hFF, 1'b1, 1'b1, '{KIND_END, 8'h00, STATUS_HDR_BAD, 8'h00, 8'h00, 8'h00});
    // Zero length with a good header
    put_row(8'hFF, 1'b1);
    put_row(8'hFF, 1'b1);
    put_row(8'h00, 1'b1);
    put_row(8'hFE, 1'b1, 1'b1, '{KIND_END, 8'h00, STATUS_OK, 8'hFF, 8'hFF, 8'h00});
    // Two payload bytes at the extremes, good payload sum
    put_row(8'h5A, 1'b1);
    put_row(8'hA5, 1'b1);
    put_row(8'h02, 1'b1);
    put_row(8'h01, 1'b1);
    put_row(8'h00, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'h00, STATUS_OK, 8'h00, 8'h00, 8'h00});
    put_row(8'hFF, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'hFF, STATUS_OK, 8'h00, 8'h00, 8'h00});
    put_row(8'hFF, 1'b1, 1'b1, '{KIND_END, 8'h00, STATUS_OK, 8'h5A, 8'hA5, 8'h02});
    // Bad payload sum, checked by the predictor
    put_row(8'h01);
    put_row(8'h80);
    put_row(8'h01);
    put_row(8'h82);
    put_row(8'h7F);
    put_row(8'h00);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].yields,
                directed_rows[i].want);

    // Random traffic: frames plus some line noise that knocks the framing off
    while (sent_bytes < directed_rows.size() + RANDOM_BYTES) begin
      if ($urandom_range(0, 99) < 8)
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
      else
        send_frame();
    end
    rx_valid <= 1'b0;

    while (pending_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("packet_deframer_sum_check_unit verification clean");
    else
      $display("packet_deframer_sum_check_unit verification failed");
    $finish;
  end

endmodule
`default_nettype wire
